@@ hw/rtl/aarm_pkg.sv @@
// ----------------------------------------------------------------------------
// aarm_pkg: shared types and constants of the axis-angle to rotation matrix
// pipeline. Holds the Q30 angle constants, the arctangent ROM and the
// structs that travel from one cell to the next.
// ----------------------------------------------------------------------------
package aarm_pkg;

   // Defaults of the top-level parameters.
   localparam int unsigned ANGLE_WIDTH_DEF   = 16;
   localparam int unsigned CORDIC_STAGES_DEF = 16;

   // Fixed cell counts of the root and quotient chains.
   localparam int unsigned SQRT_CELLS = 16;
   localparam int unsigned DIV_CELLS  = 31;

   // Q30 constants (angles as 34-bit unsigned magnitudes) and one in Q14.
   localparam logic [33:0] TWO_PI_Q30    = 34'd6746518852;
   localparam logic [33:0] TWO_PI_X2_Q30 = 34'd13493037704;
   localparam logic [33:0] PI_Q30        = 34'd3373259426;
   localparam logic [33:0] HALF_PI_Q30   = 34'd1686629713;
   localparam logic [33:0] FOLD_HI_Q30   = 34'd5059889139;
   localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
   localparam logic signed [34:0] ONE_Q30  = 35'sd1073741824;
   localparam logic signed [19:0] Q14_ONE  = 20'sd16384;

   // Arctangent of 2^-i in Q30, truncated up to i = 26, rounded after.
   localparam logic [31:0] ATAN_Q30 [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   // Rotation vector as it enters.
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } vec_type;

   // Square root cell data: remaining radicand, partial remainder, root.
   typedef struct packed {
      logic [31:0] rad;
      logic [17:0] rem;
      logic [15:0] root;
   } sqrt_type;

   // Quotient cell data for the three axis components.
   typedef struct packed {
      logic [15:0]           den;
      logic [2:0][15:0]      rem;
      logic [2:0][30:0]      quo;
   } div_type;

   // Control that travels beside the quotient chain.
   typedef struct packed {
      logic        ident;
      logic [15:0] angle;
      logic [2:0]  neg;
   } dside_type;

   // CORDIC cell data.
   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
   } cordic_type;

   // Axis and control that travel beside the CORDIC chain.
   typedef struct packed {
      logic signed [2:0][31:0] n;
      logic                    ident;
      logic                    flip;
   } cside_type;

endpackage

@@ hw/rtl/aarm_chan_if.sv @@
// ----------------------------------------------------------------------------
// aarm channel interfaces: valid/ready channels for rotation vectors in and
// rotation matrices out.
// ----------------------------------------------------------------------------
interface aarm_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] axis_x;
   logic signed [15:0] axis_y;
   logic signed [15:0] axis_z;

   modport source (output valid, output axis_x, output axis_y, output axis_z,
                   input ready);
   modport sink   (input valid, input axis_x, input axis_y, input axis_z,
                   output ready);
endinterface

interface aarm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] m00;
   logic signed [15:0] m01;
   logic signed [15:0] m02;
   logic signed [15:0] m10;
   logic signed [15:0] m11;
   logic signed [15:0] m12;
   logic signed [15:0] m20;
   logic signed [15:0] m21;
   logic signed [15:0] m22;

   modport source (output valid, output m00, output m01, output m02,
                   output m10, output m11, output m12,
                   output m20, output m21, output m22, input ready);
   modport sink   (input valid, input m00, input m01, input m02,
                   input m10, input m11, input m12,
                   input m20, input m21, input m22, output ready);
endinterface

@@ hw/rtl/aarm_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// aarm_sqrt_cell: one digit of a pipelined integer square root.
// Takes two radicand bits, produces one root bit and hands on the rest.
// ----------------------------------------------------------------------------
module aarm_sqrt_cell (
   input  logic               clock,
   input  logic               adv,
   input  aarm_pkg::sqrt_type sq_in,
   output aarm_pkg::sqrt_type sq_out
);
   import aarm_pkg::*;

   logic [19:0] part;
   logic [19:0] trial;
   sqrt_type    sq_in_nxt;
   sqrt_type    sq_ff;

   // Restoring step: try to subtract 4*root+1 from the remainder.
   always_comb begin
      part  = {sq_in.rem, sq_in.rad[31:30]};
      trial = {2'b00, sq_in.root, 2'b01};
      sq_in_nxt.rad = {sq_in.rad[29:0], 2'b00};
      if (part >= trial) begin
         sq_in_nxt.rem  = 18'(part - trial);
         sq_in_nxt.root = {sq_in.root[14:0], 1'b1};
      end else begin
         sq_in_nxt.rem  = part[17:0];
         sq_in_nxt.root = {sq_in.root[14:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff <= sq_in_nxt;
      end
   end

   assign sq_out = sq_ff;
endmodule

@@ hw/rtl/aarm_div_cell.sv @@
// ----------------------------------------------------------------------------
// aarm_div_cell: one quotient bit of a pipelined restoring divider, for all
// three axis components against the shared root.
// ----------------------------------------------------------------------------
module aarm_div_cell (
   input  logic              clock,
   input  logic              adv,
   input  logic [2:0]        num_bit,
   input  aarm_pkg::div_type dv_in,
   output aarm_pkg::div_type dv_out
);
   import aarm_pkg::*;

   logic [2:0][16:0] part;
   div_type          dv_in_nxt;
   div_type          dv_ff;

   // Shift in the next numerator bit and subtract the root where it fits.
   always_comb begin
      dv_in_nxt.den = dv_in.den;
      for (int k = 0; k < 3; k++) begin
         part[k] = {dv_in.rem[k], num_bit[k]};
         if (part[k] >= {1'b0, dv_in.den}) begin
            dv_in_nxt.rem[k] = 16'(part[k] - {1'b0, dv_in.den});
            dv_in_nxt.quo[k] = {dv_in.quo[k][29:0], 1'b1};
         end else begin
            dv_in_nxt.rem[k] = part[k][15:0];
            dv_in_nxt.quo[k] = {dv_in.quo[k][29:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff <= dv_in_nxt;
      end
   end

   assign dv_out = dv_ff;
endmodule

@@ hw/rtl/aarm_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// aarm_cordic_cell: one micro-rotation of a rotation-mode CORDIC in Q30.
// ----------------------------------------------------------------------------
module aarm_cordic_cell #(
   parameter int unsigned SHIFT = 0
) (
   input  logic                 clock,
   input  logic                 adv,
   input  aarm_pkg::cordic_type cr_in,
   output aarm_pkg::cordic_type cr_out
);
   import aarm_pkg::*;

   logic signed [33:0] x_sh;
   logic signed [33:0] y_sh;
   logic signed [33:0] step;
   cordic_type         cr_in_nxt;
   cordic_type         cr_ff;

   // Rotate toward zero residual angle; shifts are arithmetic (floor).
   always_comb begin
      x_sh = cr_in.x >>> SHIFT;
      y_sh = cr_in.y >>> SHIFT;
      step = $signed({2'b00, ATAN_Q30[SHIFT]});
      if (cr_in.z >= 0) begin
         cr_in_nxt.x = cr_in.x - y_sh;
         cr_in_nxt.y = cr_in.y + x_sh;
         cr_in_nxt.z = cr_in.z - step;
      end else begin
         cr_in_nxt.x = cr_in.x + y_sh;
         cr_in_nxt.y = cr_in.y - x_sh;
         cr_in_nxt.z = cr_in.z + step;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cr_ff <= cr_in_nxt;
      end
   end

   assign cr_out = cr_ff;
endmodule

@@ hw/rtl/axis_angle_to_rotation_matrix.sv @@
// ----------------------------------------------------------------------------
// axis_angle_to_rotation_matrix: rotation vector to 3x3 rotation matrix.
// Fully pipelined Rodrigues formula built from chains of cells: a root
// chain for the angle, a quotient chain for the unit axis and a CORDIC
// chain for sine and cosine, followed by the product and output stages.
//
//   channel   dir   payload                      beat condition
//   req_bus   in    axis_x/y/z  (Q3.12)          valid && ready
//   rsp_bus   out   m00..m22    (Q1.14)          valid && ready
//   csr_*     in    min_angle   (8 bit)          csr_wr_en
//
// One beat is accepted every cycle while the output beat is not held; the
// path runs through 16 root cells, 31 quotient cells and the CORDIC cells.
// Reset clears all valid bits and sets min_angle to 1; no clearing pass.
// When the output beat is held, the whole pipeline holds and req_bus.ready
// drops in the same cycle.
// ----------------------------------------------------------------------------
module axis_angle_to_rotation_matrix #(
   parameter int unsigned ANGLE_WIDTH   = aarm_pkg::ANGLE_WIDTH_DEF,
   parameter int unsigned CORDIC_STAGES = aarm_pkg::CORDIC_STAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   aarm_req_if.sink    req_bus,
   aarm_rsp_if.source  rsp_bus,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);
   import aarm_pkg::*;

   localparam int unsigned LAT = 55 + CORDIC_STAGES;
   localparam int unsigned ANGLE_MAX_INT =
      (ANGLE_WIDTH >= 16) ? 65535 : ((1 << ANGLE_WIDTH) - 1);
   localparam logic [15:0] ANGLE_MAX = 16'(ANGLE_MAX_INT);

   logic            adv;
   logic [LAT-1:0]  vld_ff;
   logic [7:0]      min_angle_ff;

   // Pipeline advances unless a finished beat is waiting.
   assign adv           = !rsp_bus.valid || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign rsp_bus.valid = vld_ff[LAT-1];

   // Valid bits and configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         min_angle_ff <= 8'd1;
      end else begin
         if (adv) begin
            vld_ff <= {vld_ff[LAT-2:0], req_bus.valid};
         end
         if (csr_wr_en) begin
            min_angle_ff <= csr_wr_data;
         end
      end
   end

   // Input stage: register the vector and its squared length.
   vec_type     v_ff;
   logic [31:0] sq_ff;
   logic [31:0] sq_in;

   always_comb begin
      sq_in = 32'(32'($signed(req_bus.axis_x) * $signed(req_bus.axis_x)))
            + 32'(32'($signed(req_bus.axis_y) * $signed(req_bus.axis_y)))
            + 32'(32'($signed(req_bus.axis_z) * $signed(req_bus.axis_z)));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v_ff  <= '{x: req_bus.axis_x, y: req_bus.axis_y, z: req_bus.axis_z};
         sq_ff <= sq_in;
      end
   end

   // Square root chain with the vector carried alongside.
   sqrt_type sq_w [SQRT_CELLS+1];
   vec_type  v_dly_ff [SQRT_CELLS];

   assign sq_w[0] = '{rad: sq_ff, rem: '0, root: '0};

   for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
      aarm_sqrt_cell u_cell (
         .clock  (clock),
         .adv    (adv),
         .sq_in  (sq_w[g]),
         .sq_out (sq_w[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v_dly_ff[0] <= v_ff;
         for (int i = 1; i < SQRT_CELLS; i++) begin
            v_dly_ff[i] <= v_dly_ff[i-1];
         end
      end
   end

   // Angle stage: saturate, decide identity, set up the division.
   logic [15:0]      root;
   logic [15:0]      angle_in;
   logic [2:0][15:0] mag_in;
   logic [2:0]       neg_in;
   vec_type          v_root;
   div_type          dv0_ff;
   dside_type        ds0_ff;
   logic [2:0]       lsb_ff;

   always_comb begin
      root     = sq_w[SQRT_CELLS].root;
      v_root   = v_dly_ff[SQRT_CELLS-1];
      angle_in = (root > ANGLE_MAX) ? ANGLE_MAX : root;
      neg_in   = {v_root.z[15], v_root.y[15], v_root.x[15]};
      mag_in[0] = v_root.x[15] ? 16'(-v_root.x) : 16'(v_root.x);
      mag_in[1] = v_root.y[15] ? 16'(-v_root.y) : 16'(v_root.y);
      mag_in[2] = v_root.z[15] ? 16'(-v_root.z) : 16'(v_root.z);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv0_ff.den <= root;
         for (int k = 0; k < 3; k++) begin
            dv0_ff.rem[k] <= {1'b0, mag_in[k][15:1]};
            dv0_ff.quo[k] <= '0;
            lsb_ff[k]     <= mag_in[k][0];
         end
         ds0_ff.ident <= (root == 16'd0) || (angle_in < {8'd0, min_angle_ff});
         ds0_ff.angle <= angle_in;
         ds0_ff.neg   <= neg_in;
      end
   end

   // Quotient chain: unit axis in Q30, control carried alongside.
   div_type   dv_w [DIV_CELLS+1];
   dside_type ds_dly_ff [DIV_CELLS];

   assign dv_w[0] = dv0_ff;

   for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
      aarm_div_cell u_cell (
         .clock   (clock),
         .adv     (adv),
         .num_bit ((g == 0) ? lsb_ff : 3'b000),
         .dv_in   (dv_w[g]),
         .dv_out  (dv_w[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ds_dly_ff[0] <= ds0_ff;
         for (int i = 1; i < DIV_CELLS; i++) begin
            ds_dly_ff[i] <= ds_dly_ff[i-1];
         end
      end
   end

   // Axis sign and first phase reduction.
   dside_type   ds_end;
   cside_type   n_side_ff;
   logic [33:0] ph;
   logic [33:0] ph1_ff;
   logic [33:0] ph1_in;

   always_comb begin
      ds_end = ds_dly_ff[DIV_CELLS-1];
      ph     = {ds_end.angle, 18'd0};
      ph1_in = (ph >= TWO_PI_X2_Q30) ? ph - TWO_PI_X2_Q30 : ph;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            n_side_ff.n[k] <= ds_end.neg[k] ? -$signed({1'b0, dv_w[DIV_CELLS].quo[k]})
                                            : $signed({1'b0, dv_w[DIV_CELLS].quo[k]});
         end
         n_side_ff.ident <= ds_end.ident;
         n_side_ff.flip  <= 1'b0;
         ph1_ff          <= ph1_in;
      end
   end

   // Phase brought below two pi.
   cside_type   p2_side_ff;
   logic [33:0] ph2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_side_ff <= n_side_ff;
         ph2_ff     <= (ph1_ff >= TWO_PI_Q30) ? ph1_ff - TWO_PI_Q30 : ph1_ff;
      end
   end

   // Fold into [-pi/2, pi/2]; the cosine sign flips when folded.
   logic signed [33:0] fold_in;
   logic               flip_in;
   cordic_type         cr0_ff;
   cside_type          p3_side_ff;

   always_comb begin
      if (ph2_ff <= HALF_PI_Q30) begin
         fold_in = $signed(ph2_ff);
         flip_in = 1'b0;
      end else if (ph2_ff < FOLD_HI_Q30) begin
         fold_in = $signed(PI_Q30 - ph2_ff);
         flip_in = 1'b1;
      end else begin
         fold_in = $signed(ph2_ff - TWO_PI_Q30);
         flip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cr0_ff           <= '{x: GAIN_Q30, y: '0, z: fold_in};
         p3_side_ff.n     <= p2_side_ff.n;
         p3_side_ff.ident <= p2_side_ff.ident;
         p3_side_ff.flip  <= flip_in;
      end
   end

   // CORDIC chain with axis carried alongside.
   cordic_type cr_w [CORDIC_STAGES+1];
   cside_type  cs_dly_ff [CORDIC_STAGES];

   assign cr_w[0] = cr0_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      aarm_cordic_cell #(.SHIFT(g)) u_cell (
         .clock  (clock),
         .adv    (adv),
         .cr_in  (cr_w[g]),
         .cr_out (cr_w[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cs_dly_ff[0] <= p3_side_ff;
         for (int i = 1; i < CORDIC_STAGES; i++) begin
            cs_dly_ff[i] <= cs_dly_ff[i-1];
         end
      end
   end

   // First product stage: n_i*n_j and sin times the cross terms.
   // Order of the six symmetric pairs: 00, 11, 22, 01, 02, 12.
   // Order of the six cross terms: 01, 02, 10, 12, 20, 21.
   // Packed array elements read as unsigned; products and sums re-sign them.
   cside_type               cs_end;
   logic signed [33:0]      sin_v;
   logic signed [33:0]      cos_v;
   logic signed [5:0][31:0] pn_in;
   logic signed [5:0][33:0] qs_in;
   logic signed [5:0][31:0] kv;
   logic signed [63:0]      pp [6];
   logic signed [65:0]      qp [6];
   logic signed [5:0][31:0] pn_ff;
   logic signed [5:0][33:0] qs1_ff;
   logic signed [34:0]      omc1_ff;
   logic signed [33:0]      cos1_ff;
   logic                    ident1_ff;

   always_comb begin
      cs_end = cs_dly_ff[CORDIC_STAGES-1];
      sin_v  = cr_w[CORDIC_STAGES].y;
      cos_v  = cs_end.flip ? -cr_w[CORDIC_STAGES].x : cr_w[CORDIC_STAGES].x;
      pp[0] = $signed(cs_end.n[0]) * $signed(cs_end.n[0]);
      pp[1] = $signed(cs_end.n[1]) * $signed(cs_end.n[1]);
      pp[2] = $signed(cs_end.n[2]) * $signed(cs_end.n[2]);
      pp[3] = $signed(cs_end.n[0]) * $signed(cs_end.n[1]);
      pp[4] = $signed(cs_end.n[0]) * $signed(cs_end.n[2]);
      pp[5] = $signed(cs_end.n[1]) * $signed(cs_end.n[2]);
      kv[0] = -cs_end.n[2];
      kv[1] =  cs_end.n[1];
      kv[2] =  cs_end.n[2];
      kv[3] = -cs_end.n[0];
      kv[4] = -cs_end.n[1];
      kv[5] =  cs_end.n[0];
      for (int k = 0; k < 6; k++) begin
         pn_in[k] = 32'(pp[k] >>> 30);
         qp[k]    = sin_v * $signed(kv[k]);
         qs_in[k] = 34'(qp[k] >>> 30);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pn_ff     <= pn_in;
         qs1_ff    <= qs_in;
         omc1_ff   <= ONE_Q30 - 35'(cos_v);
         cos1_ff   <= cos_v;
         ident1_ff <= cs_end.ident;
      end
   end

   // Second product stage: (1 - cos) times the outer product.
   logic signed [66:0]      tp [6];
   logic signed [5:0][33:0] tn_in;
   logic signed [5:0][33:0] tn_ff;
   logic signed [5:0][33:0] qs2_ff;
   logic signed [33:0]      cos2_ff;
   logic                    ident2_ff;

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         tp[k]    = omc1_ff * $signed(pn_ff[k]);
         tn_in[k] = 34'(tp[k] >>> 30);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tn_ff     <= tn_in;
         qs2_ff    <= qs1_ff;
         cos2_ff   <= cos1_ff;
         ident2_ff <= ident1_ff;
      end
   end

   // Output stage: sum, round to Q1.14 and saturate, or force the identity.
   logic signed [8:0][35:0] sum;
   logic signed [8:0][19:0] rnd;
   logic signed [8:0][15:0] m_in;
   logic signed [8:0][15:0] m_ff;
   logic                    ident_out_ff;

   always_comb begin
      sum[0] = 36'($signed(tn_ff[0])) + 36'(cos2_ff);
      sum[4] = 36'($signed(tn_ff[1])) + 36'(cos2_ff);
      sum[8] = 36'($signed(tn_ff[2])) + 36'(cos2_ff);
      sum[1] = 36'($signed(tn_ff[3])) + 36'($signed(qs2_ff[0]));
      sum[2] = 36'($signed(tn_ff[4])) + 36'($signed(qs2_ff[1]));
      sum[3] = 36'($signed(tn_ff[3])) + 36'($signed(qs2_ff[2]));
      sum[5] = 36'($signed(tn_ff[5])) + 36'($signed(qs2_ff[3]));
      sum[6] = 36'($signed(tn_ff[4])) + 36'($signed(qs2_ff[4]));
      sum[7] = 36'($signed(tn_ff[5])) + 36'($signed(qs2_ff[5]));
      for (int k = 0; k < 9; k++) begin
         rnd[k] = 20'(($signed(sum[k]) + 36'sd32768) >>> 16);
         if (ident2_ff) begin
            m_in[k] = (k % 4 == 0) ? 16'(Q14_ONE) : 16'sd0;
         end else if ($signed(rnd[k]) > Q14_ONE) begin
            m_in[k] = 16'(Q14_ONE);
         end else if ($signed(rnd[k]) < -Q14_ONE) begin
            m_in[k] = 16'(-Q14_ONE);
         end else begin
            m_in[k] = 16'(rnd[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff         <= m_in;
         ident_out_ff <= ident2_ff;
      end
   end

   assign rsp_bus.m00 = m_ff[0];
   assign rsp_bus.m01 = m_ff[1];
   assign rsp_bus.m02 = m_ff[2];
   assign rsp_bus.m10 = m_ff[3];
   assign rsp_bus.m11 = m_ff[4];
   assign rsp_bus.m12 = m_ff[5];
   assign rsp_bus.m20 = m_ff[6];
   assign rsp_bus.m21 = m_ff[7];
   assign rsp_bus.m22 = m_ff[8];

   // A held output beat must stall the input side.
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("input accepted while output beat is held");

   // Nothing comes out in the cycle after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_bus.valid)
      else $error("output valid right after reset");

   // Identity results: unit diagonal, zero m01, m12 and m20.
   a_identity_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && ident_out_ff) |->
         (rsp_bus.m00 == 16'sd16384 && rsp_bus.m11 == 16'sd16384 &&
          rsp_bus.m22 == 16'sd16384 && rsp_bus.m01 == 16'sd0 &&
          rsp_bus.m12 == 16'sd0 && rsp_bus.m20 == 16'sd0))
      else $error("identity result malformed");

   // Saturation keeps entries in [-1, 1]; m00 and m12 are checked.
   a_entry_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |->
         (rsp_bus.m00 <= 16'sd16384 && rsp_bus.m00 >= -16'sd16384 &&
          rsp_bus.m12 <= 16'sd16384 && rsp_bus.m12 >= -16'sd16384))
      else $error("matrix entry out of range");

   // A register write takes effect at the next edge.
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (min_angle_ff == $past(csr_wr_data)))
      else $error("min_angle not updated");

endmodule
